/* src/tbbss_pkg.sv */
// Shared types and constants for the two-bit bitmap state search block.
// Used by the store, match unit, controller and top level; no dependencies.
package tbbss_pkg;

  // Bitmap geometry: 32 two-bit entries per 64-bit word.
  localparam int BitmapWords    = 512;
  localparam int AddrW          = $clog2(BitmapWords);
  localparam int CntW           = AddrW + 1;
  localparam int WordW          = 64;
  localparam int EntriesPerWord = 32;
  localparam int EntW           = $clog2(EntriesPerWord);
  localparam int BytesW         = 13;
  localparam int BlockW         = 14;
  localparam int TailW          = 3;

  // Reset value of the bitmap length register, in bytes.
  localparam logic [BytesW-1:0] BytesReset = 13'd4096;

  // Operation codes of an input item.
  localparam logic OpLoad   = 1'b0;
  localparam logic OpSearch = 1'b1;

  // Input item as transferred on the input channel.
  typedef struct packed {
    logic              operation;
    logic [8:0]        word_index;
    logic [WordW-1:0]  word_data;
    logic [BlockW-1:0] goal_block;
    logic [1:0]        wanted_state;
  } in_item_t;

  // Result item as transferred on the output channel.
  typedef struct packed {
    logic              found;
    logic [BlockW-1:0] block_number;
  } out_item_t;

  // Request from the controller to the match unit for the word being checked.
  typedef struct packed {
    logic [1:0]      state;
    logic            use_goal;
    logic [EntW-1:0] goal_ent;
    logic            use_tail;
    logic [TailW-1:0] tail_bytes;
  } tbbss_mreq_t;

  // Match unit answer: any hit, and the lowest matching entry.
  typedef struct packed {
    logic            hit;
    logic [EntW-1:0] entry;
  } tbbss_mres_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } tbbss_state_e;

endpackage

/* src/tbbss_store.sv */
// Bitmap word memory: one write port and one registered read port.
// Depends on tbbss_pkg for the depth and word width.
module tbbss_store import tbbss_pkg::*; (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WordW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WordW-1:0] rd_data_o
);

  logic [WordW-1:0] mem_q [BitmapWords];
  logic [WordW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/tbbss_match.sv */
// Match unit: compares all 32 entries of one bitmap word against the wanted
// state, applies the goal and tail masks and finds the lowest hit. Uses tbbss_pkg.
module tbbss_match import tbbss_pkg::*; (
  input  logic [WordW-1:0] word_i,
  input  tbbss_mreq_t      req_i,
  output tbbss_mres_t      res_o
);

  logic [EntriesPerWord-1:0] hit_vec;
  logic [EntW-1:0]           tail_lim;

  // Entries below four times the tail byte count lie inside a partial word.
  assign tail_lim = {req_i.tail_bytes, 2'b00};

  // Per-entry compare with the goal mask on the first word and the tail mask
  // on a partial last word.
  always_comb begin
    for (int i = 0; i < EntriesPerWord; i++) begin
      hit_vec[i] = (word_i[2*i +: 2] == req_i.state)
                 && (!req_i.use_goal || (EntW'(i) >= req_i.goal_ent))
                 && (!req_i.use_tail || (EntW'(i) < tail_lim));
    end
  end

  // Lowest set bit of the hit vector.
  always_comb begin
    res_o.hit   = |hit_vec;
    res_o.entry = '0;
    for (int i = EntriesPerWord - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        res_o.entry = EntW'(i);
      end
    end
  end

endmodule

/* src/tbbss_ctrl.sv */
// Sequencer of the bitmap search: input and output handshakes, length register,
// read address walk over the store and result capture. Uses tbbss_pkg.
module tbbss_ctrl import tbbss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BytesW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  output logic              wr_en_o,
  output logic [AddrW-1:0]  wr_addr_o,
  output logic [WordW-1:0]  wr_data_o,
  output logic              rd_en_o,
  output logic [AddrW-1:0]  rd_addr_o,
  output tbbss_mreq_t       mreq_o,
  input  tbbss_mres_t       mres_i
);

  tbbss_state_e state_q, state_d;

  logic [BytesW-1:0] bytes_q;
  logic [CntW-1:0]   rd_word_q, rd_word_d;
  logic [AddrW-1:0]  last_word_q, last_word_d;
  logic [AddrW-1:0]  chk_word_q, chk_word_d;
  logic              chk_valid_q, chk_valid_d;
  logic              first_q, first_d;
  logic [EntW-1:0]   goal_ent_q, goal_ent_d;
  logic [1:0]        wanted_q, wanted_d;
  logic [TailW-1:0]  tail_q, tail_d;
  out_item_t         res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              in_accept;
  logic              search_start;
  logic [10:0]       words_full;
  logic [CntW-1:0]   words;
  logic [TailW-1:0]  tail_eff;
  logic [AddrW-1:0]  goal_word;
  logic              goal_past;
  logic              issue;
  logic              chk_last;
  logic              scan_hit;
  logic              scan_end;
  logic              out_free;

  // Input transfer and load path into the store.
  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign search_start = in_accept && (in_data_i.operation == OpSearch);
  assign wr_en_o      = in_accept && (in_data_i.operation == OpLoad);
  assign wr_addr_o    = in_data_i.word_index;
  assign wr_data_o    = in_data_i.word_data;

  // Valid word count from the byte length, clamped to the store depth.
  assign words_full = 11'(({1'b0, bytes_q} + 14'd7) >> 3);
  always_comb begin
    if (words_full > 11'(BitmapWords)) begin
      words    = CntW'(BitmapWords);
      tail_eff = '0;
    end else begin
      words    = words_full[CntW-1:0];
      tail_eff = bytes_q[TailW-1:0];
    end
  end
  assign goal_word = in_data_i.goal_block[BlockW-1:EntW];
  assign goal_past = ({1'b0, goal_word} >= words);

  // Scan status of the word whose data stands at the store output.
  assign issue    = (rd_word_q <= {1'b0, last_word_q});
  assign chk_last = chk_valid_q && (chk_word_q == last_word_q);
  assign scan_hit = chk_valid_q && mres_i.hit;
  assign scan_end = scan_hit || chk_last;
  assign out_free = !out_valid_q || !out_stall_i;

  // Request to the match unit.
  assign mreq_o.state      = wanted_q;
  assign mreq_o.use_goal   = first_q;
  assign mreq_o.goal_ent   = goal_ent_q;
  assign mreq_o.use_tail   = (chk_word_q == last_word_q) && (tail_q != '0);
  assign mreq_o.tail_bytes = tail_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (search_start) begin
          state_d = goal_past ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath controls and next values.
  always_comb begin
    rd_word_d   = rd_word_q;
    last_word_d = last_word_q;
    chk_word_d  = chk_word_q;
    chk_valid_d = 1'b0;
    first_d     = first_q;
    goal_ent_d  = goal_ent_q;
    wanted_d    = wanted_q;
    tail_d      = tail_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (search_start) begin
          rd_word_d   = {1'b0, goal_word};
          last_word_d = AddrW'(words - CntW'(1));
          first_d     = 1'b1;
          goal_ent_d  = in_data_i.goal_block[EntW-1:0];
          wanted_d    = in_data_i.wanted_state;
          tail_d      = tail_eff;
          res_d       = '0;
        end
      end
      ST_SCAN: begin
        rd_en_o     = issue && !scan_end;
        chk_valid_d = rd_en_o;
        chk_word_d  = rd_word_q[AddrW-1:0];
        if (rd_en_o) begin
          rd_word_d = rd_word_q + CntW'(1);
        end
        if (chk_valid_q) begin
          first_d = 1'b0;
        end
        if (scan_hit) begin
          res_d.found        = 1'b1;
          res_d.block_number = {chk_word_q, mres_i.entry};
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_addr_o   = rd_word_q[AddrW-1:0];
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bytes_q     <= BytesReset;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        bytes_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_word_q   <= rd_word_d;
    last_word_q <= last_word_d;
    chk_word_q  <= chk_word_d;
    first_q     <= first_d;
    goal_ent_q  <= goal_ent_d;
    wanted_q    <= wanted_d;
    tail_q      <= tail_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

endmodule

/* src/two_bit_bitmap_state_search.sv */
// Two-bit bitmap state search. The block holds a 512-word bitmap with two bits
// per block, 32 blocks per 64-bit word. A load item writes one word and gives
// no result. A search item returns the first block at or after the goal whose
// entry equals the wanted state, ignoring entries beyond the configured byte
// length. A search reads one word per cycle through the single read port of
// the bitmap memory; the input is stalled while a search runs. A search must
// only touch words that were loaded before. Depends on tbbss_pkg and the
// tbbss_ctrl, tbbss_store and tbbss_match modules.
module two_bit_bitmap_state_search import tbbss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BytesW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [WordW-1:0] wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [WordW-1:0] rd_data;
  tbbss_mreq_t      mreq;
  tbbss_mres_t      mres;

  // Sequencer with handshakes, length register and result register.
  tbbss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .mreq_o      (mreq),
    .mres_i      (mres)
  );

  // Bitmap memory.
  tbbss_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Shared word compare and lowest-hit unit.
  tbbss_match u_match (
    .word_i (rd_data),
    .req_i  (mreq),
    .res_o  (mres)
  );

endmodule

/* tb/sv/tb_two_bit_bitmap_state_search.sv */
// Self-checking testbench for the two-bit bitmap state search block.
// Depends on tbbss_pkg and two_bit_bitmap_state_search; it predicts the untyped searches.
`timescale 1ns / 1ps

module tb_two_bit_bitmap_state_search;
  import tbbss_pkg::*;

  localparam int QuietLimit  = 4000;
  localparam int LoadSettle  = 8;
  localparam int EndSettle   = 32;
  localparam int NumPhases   = 10;
  localparam int PhaseItems  = 62;
  localparam int PrintLimit  = 40;

  typedef enum logic [1:0] {
    RowLoad,
    RowSearch,
    RowLength
  } row_kind_e;

  // One line of the directed table; arg is the word index, goal or byte length.
  typedef struct packed {
    row_kind_e         kind;
    logic [13:0]       arg;
    logic [WordW-1:0]  data;
    logic [1:0]        want;
    logic              typed;
    logic              found;
    logic [BlockW-1:0] blk;
  } dir_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [BytesW-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_item_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_data_o;

  // Local copy of the block's state and length register.
  logic [WordW-1:0]  bitmap_copy [BitmapWords];
  int unsigned       length_bytes = 32'(BytesReset);

  out_item_t         expected_hits [$];
  dir_row_t          dir_rows [$];
  bit                idle_on = 1'b1;
  int                error_count = 0;
  int                quiet_cycles = 0;
  int                loads_sent = 0;
  int                searches_sent = 0;
  int                hits_seen = 0;
  int                lengths_written = 0;

  two_bit_bitmap_state_search u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // First block at or after the goal whose entry equals the wanted state.
  function automatic out_item_t first_match_block(logic [BlockW-1:0] goal, logic [1:0] want);
    int unsigned       nwords;
    int unsigned       tail;
    int unsigned       w;
    logic [WordW-1:0]  same;
    logic [WordW-1:0]  mask;
    logic [WordW-1:0]  hit;
    out_item_t         answer;
    answer = '0;
    hit    = '0;
    nwords = (length_bytes + 7) >> 3;
    tail   = length_bytes & 7;
    if (nwords > BitmapWords) begin
      nwords = BitmapWords;
      tail   = 0;
    end
    w = 32'(goal >> 5);
    if (w >= nwords) return answer;
    mask = {32{2'b01}} << (2 * goal[4:0]);
    for (; w < nwords; w++) begin
      // An entry matches when both of its bits agree with the wanted state.
      same = ~(bitmap_copy[w] ^ {32{want}});
      hit  = same & (same >> 1) & mask;
      if (w + 1 == nwords && tail != 0) hit &= (64'd1 << (8 * tail)) - 64'd1;
      if (hit != '0) break;
      mask = {32{2'b01}};
    end
    if (hit != '0) begin
      for (int e = 0; e < EntriesPerWord; e++) begin
        if (hit[2*e]) begin
          answer.found        = 1'b1;
          answer.block_number = BlockW'(w * EntriesPerWord + e);
          break;
        end
      end
    end
    return answer;
  endfunction

  // Loads carry random noise in the fields they do not use, and so do searches.
  function automatic in_item_t load_item(int idx, logic [WordW-1:0] data);
    in_item_t it;
    it              = '0;
    it.operation    = OpLoad;
    it.word_index   = idx[8:0];
    it.word_data    = data;
    it.goal_block   = BlockW'($urandom);
    it.wanted_state = 2'($urandom);
    return it;
  endfunction

  function automatic in_item_t search_item(int goal, logic [1:0] want);
    in_item_t it;
    it              = '0;
    it.operation    = OpSearch;
    it.word_index   = 9'($urandom);
    it.word_data    = {$urandom, $urandom};
    it.goal_block   = goal[BlockW-1:0];
    it.wanted_state = want;
    return it;
  endfunction

  // Background state with up to two odd entries, else random, or uniform in a random state.
  function automatic logic [WordW-1:0] make_word(logic [1:0] bg);
    logic [WordW-1:0] w;
    logic [1:0]       s;
    int               pick;
    int               k;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      w = {32{bg}};
      repeat ($urandom_range(0, 2)) begin
        k = $urandom_range(0, 31);
        s = 2'($urandom_range(0, 3));
        w[2*k +: 2] = s;
      end
    end else if (pick < 7) begin
      w = {$urandom, $urandom};
    end else begin
      s = 2'($urandom_range(0, 3));
      w = {32{s}};
    end
    return w;
  endfunction

  function automatic void add_row(row_kind_e kind, int arg, logic [WordW-1:0] data,
                                  logic [1:0] want, bit typed, bit found, int blk);
    dir_row_t r;
    r.kind  = kind;
    r.arg   = arg[13:0];
    r.data  = data;
    r.want  = want;
    r.typed = typed;
    r.found = found;
    r.blk   = blk[BlockW-1:0];
    dir_rows.push_back(r);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < PrintLimit) begin
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    end
    error_count++;
  endtask

  // Drives one item until its transfer, then updates the local state or
  // queues the expected search answer.
  task automatic send_item(in_item_t item, bit typed, out_item_t typed_answer);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (item.operation == OpLoad) begin
      bitmap_copy[item.word_index] = item.word_data;
      loads_sent++;
    end else begin
      expected_hits.push_back(typed ? typed_answer
                              : first_match_block(item.goal_block, item.wanted_state));
      searches_sent++;
    end
  endtask

  // Length writes wait until every search has answered and the last load has settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (LoadSettle) @(posedge clk_i);
  endtask

  task automatic set_length(int unsigned bytes);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= bytes[BytesW-1:0];
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    length_bytes  = bytes;
    lengths_written++;
  endtask

  // Result stall: active runs broken by stall bursts while idling is on.
  initial begin : result_stall
    forever begin
      if (!idle_on) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Compare each result transfer with the oldest expected answer.
  always @(posedge clk_i) begin : result_check
    out_item_t want_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result, block", int'(out_data_o.block_number), 0);
      end else begin
        want_item = expected_hits.pop_front();
        if (out_data_o.found !== want_item.found) begin
          report_mismatch("found", int'(out_data_o.found), int'(want_item.found));
        end
        if (out_data_o.block_number !== want_item.block_number) begin
          report_mismatch("block_number", int'(out_data_o.block_number),
                          int'(want_item.block_number));
        end
        if (out_data_o.found === 1'b1) hits_seen++;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no transfer for %0d cycles", QuietLimit);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int          ph;
    int          n;
    int          nw;
    int          span;
    int          goal;
    int unsigned len;
    logic [1:0]  bg;
    logic [1:0]  want;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every word is loaded before any search, all entries in state 3.
    for (n = 0; n < BitmapWords; n++) send_item(load_item(n, '1), 1'b0, '0);

    // Directed table; typed answers follow from the all-3 store and the table's loads.
    add_row(RowSearch, 0,     '0, 2'd3, 1, 1, 0);
    add_row(RowSearch, 16383, '0, 2'd3, 1, 1, 16383);
    add_row(RowSearch, 0,     '0, 2'd0, 1, 0, 0);
    add_row(RowSearch, 100,   '0, 2'd1, 1, 0, 0);
    add_row(RowLoad,   0,     64'h5555_5555_5555_5555, 2'd0, 0, 0, 0);
    add_row(RowSearch, 5,     '0, 2'd1, 1, 1, 5);
    add_row(RowSearch, 0,     '0, 2'd3, 0, 0, 0);
    add_row(RowLoad,   3,     64'haaaa_aaaa_aaaa_aaaa, 2'd0, 0, 0, 0);
    add_row(RowSearch, 40,    '0, 2'd2, 1, 1, 96);
    add_row(RowLoad,   511,   64'h0, 2'd0, 0, 0, 0);
    add_row(RowSearch, 0,     '0, 2'd0, 1, 1, 16352);
    add_row(RowLoad,   200,   64'h0123_4567_89ab_cdef, 2'd0, 0, 0, 0);
    add_row(RowSearch, 6401,  '0, 2'd2, 0, 0, 0);
    // Zero length: nothing can match.
    add_row(RowLength, 0,     '0, 2'd0, 0, 0, 0);
    add_row(RowSearch, 0,     '0, 2'd3, 1, 0, 0);
    // Length past the end of the store: the last word counts in full.
    add_row(RowLength, 4097,  '0, 2'd0, 0, 0, 0);
    add_row(RowSearch, 16383, '0, 2'd0, 1, 1, 16383);
    add_row(RowLength, 8191,  '0, 2'd0, 0, 0, 0);
    add_row(RowSearch, 16360, '0, 2'd0, 0, 0, 0);
    // Partial last word: only its low four bytes take part.
    add_row(RowLength, 4092,  '0, 2'd0, 0, 0, 0);
    add_row(RowSearch, 16368, '0, 2'd0, 1, 0, 0);
    add_row(RowSearch, 16353, '0, 2'd0, 0, 0, 0);
    // Goal word past the end, and a one-byte tail word.
    add_row(RowLength, 9,     '0, 2'd0, 0, 0, 0);
    add_row(RowSearch, 64,    '0, 2'd3, 1, 0, 0);
    add_row(RowSearch, 36,    '0, 2'd3, 0, 0, 0);
    add_row(RowSearch, 33,    '0, 2'd3, 0, 0, 0);
    add_row(RowLength, 4096,  '0, 2'd0, 0, 0, 0);

    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        RowLoad: begin
          send_item(load_item(int'(dir_rows[r].arg), dir_rows[r].data), 1'b0, '0);
        end
        RowSearch: begin
          send_item(search_item(int'(dir_rows[r].arg), dir_rows[r].want), dir_rows[r].typed,
                    {dir_rows[r].found, dir_rows[r].blk});
        end
        default: begin
          set_length(32'(dir_rows[r].arg));
        end
      endcase
    end

    // Random phases, each under its own length; the last one runs without idling.
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       len = 0;
        1:       len = 8191;
        2:       len = 1;
        3:       len = 4097;
        4:       len = 7;
        5:       len = 8;
        6:       len = 4095;
        7:       len = $urandom_range(2, 4094);
        8:       len = $urandom_range(4098, 8190);
        default: len = 4096;
      endcase
      set_length(len);
      if (ph == NumPhases - 1) idle_on = 1'b0;
      nw   = (len + 7) >> 3;
      if (nw > BitmapWords) nw = BitmapWords;
      span = nw * EntriesPerWord;
      bg   = 2'($urandom_range(0, 3));
      for (n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < 35) begin
          send_item(load_item($urandom_range(0, BitmapWords - 1), make_word(bg)), 1'b0, '0);
        end else begin
          // Goals mostly inside the valid length, some anywhere, some near its end.
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: goal = (span > 0) ? $urandom_range(0, span - 1) : 0;
            6, 7:             goal = $urandom_range(0, 16383);
            default:          goal = (span > 64) ? span - $urandom_range(1, 64)
                                                 : $urandom_range(0, 63);
          endcase
          // Half the searches look for a state other than the background.
          if ($urandom_range(0, 1) == 1) want = bg + 2'($urandom_range(1, 3));
          else                           want = 2'($urandom_range(0, 3));
          send_item(search_item(goal, want), 1'b0, '0);
        end
      end
    end

    wait_idle();
    repeat (EndSettle) @(posedge clk_i);

    $display("covered %0d loads and %0d searches (%0d found) under %0d length settings",
             loads_sent, searches_sent, hits_seen, lengths_written);
    $display("mismatches counted: %0d", error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/tbbss_pkg.sv
src/tbbss_store.sv
src/tbbss_match.sv
src/tbbss_ctrl.sv
src/two_bit_bitmap_state_search.sv
tb/sv/tb_two_bit_bitmap_state_search.sv
